// ===== sv/hct_pkg.sv =====
// ----------------------------------------------------------------------------
// Hermite curve table package
// Shared types, operation codes and fixed-point constants.
// ----------------------------------------------------------------------------
package hct_pkg;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_EVAL   = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_NOMATCH = 2'd2;

    // Q16.16 one and the clamp on the normalized segment position.
    localparam logic signed [31:0] FIX_ONE = 32'sd65536;
    localparam int                 T_LIMIT = 16 * 65536;
    // Dividend of the position division: 33-bit magnitude shifted left 16.
    localparam int                 DIV_BITS = 49;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] tin;
        logic signed [31:0] tout;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CMP,
        S_REM_RD,
        S_REM_CMP,
        S_SH_RD,
        S_SH_WR,
        S_EV_RD,
        S_EV_CMP,
        S_EV_LO,
        S_EV_HI,
        S_EV_WAIT,
        S_FINISH
    } top_state_t;

    typedef enum logic [3:0] {
        E_IDLE,
        E_DIV,
        E_CLAMP,
        E_T2,
        E_T3,
        E_COEF,
        E_MAC,
        E_SAT,
        E_DONE
    } eval_state_t;

endpackage

// ===== sv/hct_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hct_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/hct_eval.sv =====
// ----------------------------------------------------------------------------
// Hermite segment evaluator
// Serial position division, then a shared multiplier for powers and blend.
// ----------------------------------------------------------------------------
module hct_eval (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [31:0]     query,
    input  hct_pkg::entry_t        left,
    input  hct_pkg::entry_t        right,
    output logic                   done,
    output logic signed [31:0]     value
);

    hct_pkg::eval_state_t state_reg, state_next;

    logic [5:0]                 cnt_reg, cnt_next;
    logic [32:0]                dx_reg, dx_next;
    logic                       neg_reg, neg_next;
    logic [hct_pkg::DIV_BITS-1:0] div_reg, div_next;
    logic [32:0]                rem_reg, rem_next;
    logic signed [21:0]         t1_reg, t1_next;
    logic signed [31:0]         t2_reg, t2_next;
    logic signed [31:0]         ca_reg, ca_next, cb_reg, cb_next;
    logic signed [31:0]         cc_reg, cc_next, cd_reg, cd_next;
    logic [2:0]                 step_reg, step_next;
    logic signed [65:0]         acc_reg, acc_next;
    logic signed [31:0]         value_reg, value_next;
    logic signed [63:0]         prod_reg;
    logic signed [31:0]         mul_a, mul_b;

    logic signed [32:0]         dx_w, num_w;
    logic [32:0]                mag_w;
    logic [33:0]                rem_sh;
    logic [33:0]                rem_sub;
    logic [hct_pkg::DIV_BITS:0] mag2;
    logic [20:0]                tmag;
    logic signed [31:0]         t3_w;
    logic signed [49:0]         shifted;

    always_comb
    begin
        dx_w    = {right.x[31], right.x} - {left.x[31], left.x};
        num_w   = {query[31], query} - {left.x[31], left.x};
        mag_w   = num_w[32] ? 33'(-num_w) : 33'(num_w);
        rem_sh  = {rem_reg, div_reg[hct_pkg::DIV_BITS-1]};
        rem_sub = rem_sh - {1'b0, dx_reg};
        mag2    = {1'b0, div_reg} + (hct_pkg::DIV_BITS+1)'(neg_reg && (rem_reg != '0));
        tmag    = (mag2 > (hct_pkg::DIV_BITS+1)'(hct_pkg::T_LIMIT))
                  ? 21'(hct_pkg::T_LIMIT) : mag2[20:0];
        t3_w    = prod_reg[47:16];
        shifted = acc_reg[65:16];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hct_pkg::E_IDLE:  if (start) state_next = (dx_w <= 0) ? hct_pkg::E_DONE
                                                                 : hct_pkg::E_DIV;
            hct_pkg::E_DIV:   if (cnt_reg == 6'd1) state_next = hct_pkg::E_CLAMP;
            hct_pkg::E_CLAMP: state_next = hct_pkg::E_T2;
            hct_pkg::E_T2:    state_next = hct_pkg::E_T3;
            hct_pkg::E_T3:    state_next = hct_pkg::E_COEF;
            hct_pkg::E_COEF:  state_next = hct_pkg::E_MAC;
            hct_pkg::E_MAC:   if (step_reg == 3'd4) state_next = hct_pkg::E_SAT;
            hct_pkg::E_SAT:   state_next = hct_pkg::E_DONE;
            hct_pkg::E_DONE:  state_next = hct_pkg::E_IDLE;
            default:          state_next = hct_pkg::E_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        dx_next    = dx_reg;
        neg_next   = neg_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        t1_next    = t1_reg;
        t2_next    = t2_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        cc_next    = cc_reg;
        cd_next    = cd_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        value_next = value_reg;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            hct_pkg::E_IDLE:
            begin
                if (start)
                begin
                    value_next = left.y;
                    dx_next    = dx_w;
                    neg_next   = num_w[32];
                    div_next   = {mag_w, 16'd0};
                    rem_next   = '0;
                    cnt_next   = 6'(hct_pkg::DIV_BITS);
                end
            end
            hct_pkg::E_DIV:
            begin
                if (!rem_sub[33])
                begin
                    rem_next = rem_sub[32:0];
                    div_next = {div_reg[hct_pkg::DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[32:0];
                    div_next = {div_reg[hct_pkg::DIV_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
            end
            hct_pkg::E_CLAMP:
            begin
                t1_next = neg_reg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
            end
            hct_pkg::E_T2:
            begin
                mul_a = 32'(t1_reg);
                mul_b = 32'(t1_reg);
            end
            hct_pkg::E_T3:
            begin
                t2_next = prod_reg[47:16];
                mul_a   = prod_reg[47:16];
                mul_b   = 32'(t1_reg);
            end
            hct_pkg::E_COEF:
            begin
                ca_next   = 2 * t3_w - 3 * t2_reg + hct_pkg::FIX_ONE;
                cb_next   = 3 * t2_reg - 2 * t3_w;
                cc_next   = t3_w - 2 * t2_reg + 32'(t1_reg);
                cd_next   = t3_w - t2_reg;
                acc_next  = '0;
                step_next = '0;
            end
            hct_pkg::E_MAC:
            begin
                case (step_reg)
                    3'd0:    begin mul_a = ca_reg; mul_b = left.y;     end
                    3'd1:    begin mul_a = cb_reg; mul_b = right.y;    end
                    3'd2:    begin mul_a = cc_reg; mul_b = left.tout;  end
                    3'd3:    begin mul_a = cd_reg; mul_b = right.tin;  end
                    default: begin mul_a = '0;     mul_b = '0;         end
                endcase
                if (step_reg != 3'd0)
                begin
                    acc_next = acc_reg + 66'(prod_reg);
                end
                step_next = step_reg + 3'd1;
            end
            hct_pkg::E_SAT:
            begin
                if (shifted > 50'sd2147483647)
                    value_next = 32'sh7fffffff;
                else if (shifted < -50'sd2147483648)
                    value_next = 32'sh80000000;
                else
                    value_next = shifted[31:0];
            end
            hct_pkg::E_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hct_pkg::E_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        dx_reg    <= dx_next;
        neg_reg   <= neg_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        t1_reg    <= t1_next;
        t2_reg    <= t2_next;
        ca_reg    <= ca_next;
        cb_reg    <= cb_next;
        cc_reg    <= cc_next;
        cd_reg    <= cd_next;
        step_reg  <= step_next;
        acc_reg   <= acc_next;
        value_reg <= value_next;
        prod_reg  <= mul_a * mul_b;
    end

    assign done  = (state_reg == hct_pkg::E_DONE);
    assign value = value_reg;

endmodule

// ===== sv/hermite_curve_table_unit.sv =====
// ----------------------------------------------------------------------------
// Hermite curve table unit
// Sorted control-point store with add, remove and cubic Hermite evaluation.
// ----------------------------------------------------------------------------
// Usage: an input transaction (in_valid, in_stall) carries kind and the point
// or query fields; every input transaction yields exactly one output
// transaction (out_valid, out_stall) with curve_value, status and the point
// count after the operation. The configuration channel (cfg_valid,
// cfg_ready) writes match_epsilon; the user must write it only while the unit
// is idle, which the unit does not enforce itself. cfg_ready is always high.
// Points live in one RAM row of x, y and both tangents, with a registered
// read. The sequencer issues a read, uses the data the next cycle, and never
// uses data read from a row in the cycle that row is written, so no
// forwarding is needed.
// An add shifts the points above its insertion place up one row; a remove
// scans for a match and shifts the later points down; an evaluate searches
// for the segment, then runs the 49-step serial division that normalizes
// the query position and the blend on one shared 32x32 multiplier. One item
// is in flight at a time; a new input is taken as soon as the previous
// result has been loaded into the output register.
// Reset empties the table and sets match_epsilon to 1; RAM contents need no
// clearing. While the receiver stalls, the result is held in the output
// register and the unit may finish at most one further item behind it.
// ----------------------------------------------------------------------------
module hermite_curve_table_unit #(
    parameter int MAX_POINTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] tangent_in,
    input  logic signed [31:0] tangent_out,
    input  logic signed [31:0] query_pos,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] curve_value,
    output logic [1:0]         status,
    output logic [4:0]         point_count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    hct_pkg::top_state_t state_reg, state_next;

    // Latched input transaction.
    logic [1:0]         kind_reg, kind_next;
    hct_pkg::entry_t    pt_reg, pt_next;
    logic signed [31:0] q_reg, q_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [15:0]        eps_reg;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    hct_pkg::entry_t    left_reg, left_next, right_reg, right_next;
    logic signed [31:0] res_value_reg, res_value_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               start_reg, start_next;

    logic               out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic [1:0]         out_status_reg;
    logic [4:0]         out_count_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    hct_pkg::entry_t    ram_wdata, ram_rdata;
    logic [hct_pkg::ENTRY_W-1:0] ram_rdata_raw;

    logic               accept;
    logic               out_free;
    logic [CNT_W:0]     lo_hi_sum;
    logic [CNT_W-1:0]   mid;
    logic signed [32:0] diff_x, diff_y;
    logic [32:0]        abs_x, abs_y;
    logic               is_match;
    logic               eval_done;
    logic signed [31:0] eval_value;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != hct_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign lo_hi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = lo_hi_sum[CNT_W:1];
    assign ram_rdata = hct_pkg::entry_t'(ram_rdata_raw);

    // Remove matches when both coordinates lie within epsilon.
    always_comb
    begin
        diff_x   = {pt_reg.x[31], pt_reg.x} - {ram_rdata.x[31], ram_rdata.x};
        diff_y   = {pt_reg.y[31], pt_reg.y} - {ram_rdata.y[31], ram_rdata.y};
        abs_x    = diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
        abs_y    = diff_y[32] ? 33'(-diff_y) : 33'(diff_y);
        is_match = (abs_x <= {17'd0, eps_reg}) && (abs_y <= {17'd0, eps_reg});
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hct_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        hct_pkg::KIND_ADD:
                            state_next = (count_reg >= CNT_W'(MAX_POINTS))
                                         ? hct_pkg::S_FINISH : hct_pkg::S_ADD_RD;
                        hct_pkg::KIND_REMOVE:
                            state_next = hct_pkg::S_REM_RD;
                        hct_pkg::KIND_EVAL:
                            state_next = (count_reg == '0)
                                         ? hct_pkg::S_FINISH : hct_pkg::S_EV_RD;
                        default:
                            state_next = hct_pkg::S_FINISH;
                    endcase
                end
            end
            hct_pkg::S_ADD_RD:
                state_next = (idx_reg == '0) ? hct_pkg::S_FINISH : hct_pkg::S_ADD_CMP;
            hct_pkg::S_ADD_CMP:
                state_next = (ram_rdata.x > pt_reg.x) ? hct_pkg::S_ADD_RD
                                                      : hct_pkg::S_FINISH;
            hct_pkg::S_REM_RD:
                state_next = (idx_reg == count_reg) ? hct_pkg::S_FINISH
                                                    : hct_pkg::S_REM_CMP;
            hct_pkg::S_REM_CMP:
                state_next = is_match ? hct_pkg::S_SH_RD : hct_pkg::S_REM_RD;
            hct_pkg::S_SH_RD:
                state_next = ((idx_reg + CNT_W'(1)) >= count_reg) ? hct_pkg::S_FINISH
                                                                  : hct_pkg::S_SH_WR;
            hct_pkg::S_SH_WR:
                state_next = hct_pkg::S_SH_RD;
            hct_pkg::S_EV_RD:
                state_next = ((hi_reg - lo_reg) > CNT_W'(1)) ? hct_pkg::S_EV_CMP
                                                              : hct_pkg::S_EV_LO;
            hct_pkg::S_EV_CMP:
                state_next = hct_pkg::S_EV_RD;
            hct_pkg::S_EV_LO:
                state_next = hct_pkg::S_EV_HI;
            hct_pkg::S_EV_HI:
                state_next = hct_pkg::S_EV_WAIT;
            hct_pkg::S_EV_WAIT:
                if (eval_done) state_next = hct_pkg::S_FINISH;
            hct_pkg::S_FINISH:
                if (out_free) state_next = hct_pkg::S_IDLE;
            default:
                state_next = hct_pkg::S_IDLE;
        endcase
    end

    // Datapath and RAM control.
    always_comb
    begin
        kind_next       = kind_reg;
        pt_next         = pt_reg;
        q_next          = q_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        start_next      = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[IDX_W-1:0];
        ram_wdata       = pt_reg;
        ram_raddr       = idx_reg[IDX_W-1:0];
        unique case (state_reg)
            hct_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = kind;
                    pt_next.x       = point_x;
                    pt_next.y       = point_y;
                    pt_next.tin     = tangent_in;
                    pt_next.tout    = tangent_out;
                    q_next          = query_pos;
                    res_value_next  = '0;
                    res_status_next = hct_pkg::STATUS_OK;
                    lo_next         = '0;
                    hi_next         = count_reg - CNT_W'(1);
                    unique case (kind)
                        hct_pkg::KIND_ADD:
                        begin
                            idx_next = count_reg;
                            if (count_reg >= CNT_W'(MAX_POINTS))
                                res_status_next = hct_pkg::STATUS_FULL;
                        end
                        hct_pkg::KIND_REMOVE:
                            idx_next = '0;
                        default:
                            idx_next = '0;
                    endcase
                end
            end
            hct_pkg::S_ADD_RD:
            begin
                ram_raddr = IDX_W'(idx_reg - CNT_W'(1));
                if (idx_reg == '0)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            hct_pkg::S_ADD_CMP:
            begin
                ram_we = 1'b1;
                if (ram_rdata.x > pt_reg.x)
                begin
                    ram_wdata = ram_rdata;
                    idx_next  = idx_reg - CNT_W'(1);
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            hct_pkg::S_REM_RD:
            begin
                if (idx_reg == count_reg)
                    res_status_next = hct_pkg::STATUS_NOMATCH;
            end
            hct_pkg::S_REM_CMP:
            begin
                if (!is_match)
                    idx_next = idx_reg + CNT_W'(1);
            end
            hct_pkg::S_SH_RD:
            begin
                ram_raddr = IDX_W'(idx_reg + CNT_W'(1));
                if ((idx_reg + CNT_W'(1)) >= count_reg)
                    count_next = count_reg - CNT_W'(1);
            end
            hct_pkg::S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + CNT_W'(1);
            end
            hct_pkg::S_EV_RD:
            begin
                if ((hi_reg - lo_reg) > CNT_W'(1))
                    ram_raddr = mid[IDX_W-1:0];
                else
                    ram_raddr = lo_reg[IDX_W-1:0];
            end
            hct_pkg::S_EV_CMP:
            begin
                if (q_reg < ram_rdata.x)
                    hi_next = mid;
                else
                    lo_next = mid;
            end
            hct_pkg::S_EV_LO:
            begin
                ram_raddr = hi_reg[IDX_W-1:0];
                left_next = ram_rdata;
            end
            hct_pkg::S_EV_HI:
            begin
                right_next = ram_rdata;
                start_next = 1'b1;
            end
            hct_pkg::S_EV_WAIT:
            begin
                if (eval_done)
                    res_value_next = eval_value;
            end
            hct_pkg::S_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hct_pkg::S_IDLE;
            count_reg      <= '0;
            eps_reg        <= 16'd1;
            start_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            start_reg <= start_next;
            if (cfg_valid && cfg_ready)
                eps_reg <= cfg_data;
            if (state_reg == hct_pkg::S_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        pt_reg         <= pt_next;
        q_reg          <= q_next;
        idx_reg        <= idx_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (state_reg == hct_pkg::S_FINISH && out_free)
        begin
            out_value_reg  <= (kind_reg == hct_pkg::KIND_EVAL) ? res_value_reg : '0;
            out_status_reg <= res_status_reg;
            out_count_reg  <= 5'(count_reg);
        end
    end

    hct_ram #(
        .WIDTH (hct_pkg::ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    hct_eval u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .query (q_reg),
        .left  (left_reg),
        .right (right_reg),
        .done  (eval_done),
        .value (eval_value)
    );

    assign out_valid   = out_valid_reg;
    assign curve_value = out_value_reg;
    assign status      = out_status_reg;
    assign point_count = out_count_reg;

endmodule

// ===== sv/hct_checker.sv =====
// ----------------------------------------------------------------------------
// Hermite curve table port checker
// Port-level properties of the curve table unit, bound to the top level.
// ----------------------------------------------------------------------------
module hct_checker #(
    parameter int MAX_POINTS = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] curve_value,
    input logic [1:0]         status,
    input logic [4:0]         point_count
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(curve_value) && $stable(status))
        else $error("stalled result changed");

    // Only one item is worked on at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while busy");

    // A rejected add reports a full table.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == hct_pkg::STATUS_FULL |-> point_count == 5'(MAX_POINTS))
        else $error("full status with room left");

    // Errors never carry a curve value.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != hct_pkg::STATUS_OK |-> curve_value == 32'sd0)
        else $error("error result carries a value");

endmodule

bind hermite_curve_table_unit hct_checker #(.MAX_POINTS(MAX_POINTS)) u_hct_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .curve_value (curve_value),
    .status      (status),
    .point_count (point_count)
);
